[hdl/sm_pkg.sv]
// ----------------------------------------------------------------------------
// sm_pkg: shared types and constants of the stack machine executor
// Opcodes, status codes, shared unit operations and the stack port structs.
// ----------------------------------------------------------------------------
package sm_pkg;

	localparam logic [7:0] OP_PUSH = 8'd1;
	localparam logic [7:0] OP_ADD  = 8'd2;
	localparam logic [7:0] OP_SUB  = 8'd3;
	localparam logic [7:0] OP_MUL  = 8'd4;
	localparam logic [7:0] OP_DIV  = 8'd5;
	localparam logic [7:0] OP_HALT = 8'd7;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_HALTED    = 3'd1;
	localparam logic [2:0] ST_UNDERFLOW = 3'd2;
	localparam logic [2:0] ST_OVERFLOW  = 3'd3;
	localparam logic [2:0] ST_DIVZERO   = 3'd4;
	localparam logic [2:0] ST_UNKNOWN   = 3'd5;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_MUL = 2'd2,
		ALU_DIV = 2'd3
	} alu_op_t;

	// request to the operand stack
	typedef struct packed {
		logic        push;     // write data at the top, depth up by one
		logic        replace;  // write data under the top, depth down by one
		logic        rd;       // read the entry under the top
		logic [31:0] data;
	} stk_cmd_t;

	// view of the operand stack
	typedef struct packed {
		logic        empty;
		logic        full;
		logic        below_two;
		logic [6:0]  depth;
		logic [31:0] top;
		logic [31:0] nxt;
	} stk_stat_t;

endpackage

[hdl/sm_alu.sv]
// ----------------------------------------------------------------------------
// sm_alu: iterative arithmetic unit
// One 33-bit adder, reused for add, sub, shift-add multiply and restoring
// signed division (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module sm_alu (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  sm_pkg::alu_op_t op,
	input  logic [31:0]     t,
	input  logic [31:0]     n,
	output logic            done,
	output logic [31:0]     res
);

	typedef enum logic [7:0] {
		A_IDLE = 8'b0000_0001,
		A_ADD  = 8'b0000_0010,
		A_NEGA = 8'b0000_0100,
		A_NEGB = 8'b0000_1000,
		A_DIV  = 8'b0001_0000,
		A_FIX  = 8'b0010_0000,
		A_MUL  = 8'b0100_0000,
		A_DONE = 8'b1000_0000
	} alu_state_t;

	alu_state_t      state_q;
	logic [4:0]      cnt_q;
	sm_pkg::alu_op_t op_q;
	logic [31:0]     a_q;
	logic [31:0]     b_q;
	logic [31:0]     acc_q;
	logic            neg_q;

	logic [31:0] add_x;
	logic [31:0] add_y;
	logic        add_sub;
	logic [32:0] sum;
	logic [31:0] rem_sh;

	assign rem_sh = {acc_q[30:0], a_q[31]};

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			A_ADD: begin
				add_x   = a_q;
				add_y   = b_q;
				add_sub = (op_q == sm_pkg::ALU_SUB);
			end
			A_NEGA: begin
				add_y   = a_q;
				add_sub = 1'b1;
			end
			A_NEGB: begin
				add_y   = b_q;
				add_sub = 1'b1;
			end
			A_DIV: begin
				add_x   = rem_sh;
				add_y   = b_q;
				add_sub = 1'b1;
			end
			A_FIX: begin
				add_y   = a_q;
				add_sub = 1'b1;
			end
			A_MUL: begin
				add_x = {acc_q[30:0], 1'b0};
				add_y = a_q & {32{b_q[31]}};
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
		sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + 33'(add_sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						unique case (op)
							sm_pkg::ALU_MUL: state_q <= A_MUL;
							sm_pkg::ALU_DIV: state_q <= A_NEGA;
							default:         state_q <= A_ADD;
						endcase
					end
				end
				A_ADD:  state_q <= A_DONE;
				A_NEGA: state_q <= A_NEGB;
				A_NEGB: state_q <= A_DIV;
				A_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (&cnt_q) state_q <= A_FIX;
				end
				A_FIX: state_q <= A_DONE;
				A_MUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (&cnt_q) state_q <= A_DONE;
				end
				A_DONE: state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				if (start) begin
					a_q   <= t;
					b_q   <= n;
					acc_q <= '0;
					op_q  <= op;
					neg_q <= t[31] ^ n[31];
				end
			end
			A_ADD: acc_q <= sum[31:0];
			A_NEGA: if (a_q[31]) a_q <= sum[31:0];
			A_NEGB: if (b_q[31]) b_q <= sum[31:0];
			A_DIV: begin
				if (sum[32]) begin
					acc_q <= sum[31:0];
					a_q   <= {a_q[30:0], 1'b1};
				end else begin
					acc_q <= rem_sh;
					a_q   <= {a_q[30:0], 1'b0};
				end
			end
			A_FIX: if (neg_q) a_q <= sum[31:0];
			A_MUL: begin
				acc_q <= sum[31:0];
				b_q   <= {b_q[30:0], 1'b0};
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign done = (state_q == A_DONE);
	assign res  = (op_q == sm_pkg::ALU_DIV) ? a_q : acc_q;

endmodule

[hdl/sm_stack.sv]
// ----------------------------------------------------------------------------
// sm_stack: operand stack
// Word memory with one write and one registered read port, the stack
// pointer and a cached copy of the top entry.
// ----------------------------------------------------------------------------
module sm_stack #(
	parameter int STACK_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sm_pkg::stk_cmd_t  cmd,
	output sm_pkg::stk_stat_t stat
);

	localparam int AW   = $clog2(STACK_DEPTH);
	localparam int SP_W = $clog2(STACK_DEPTH + 1);

	logic [31:0]     stack_mem [STACK_DEPTH];
	logic [SP_W-1:0] sp_q;
	logic [31:0]     top_q;
	logic [31:0]     rd_q;
	logic [SP_W-1:0] sp_m2;
	logic [AW-1:0]   waddr;

	assign sp_m2 = sp_q - SP_W'(2);
	assign waddr = cmd.push ? sp_q[AW-1:0] : sp_m2[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.push || cmd.replace) stack_mem[waddr] <= cmd.data;
		if (cmd.rd) rd_q <= stack_mem[sp_m2[AW-1:0]];
		if (cmd.push || cmd.replace) top_q <= cmd.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.push) begin
			sp_q <= sp_q + SP_W'(1);
		end else if (cmd.replace) begin
			sp_q <= sp_q - SP_W'(1);
		end
	end

	assign stat.empty     = (sp_q == '0);
	assign stat.full      = (sp_q == SP_W'(STACK_DEPTH));
	assign stat.below_two = (sp_q < SP_W'(2));
	assign stat.depth     = 7'(sp_q);
	assign stat.top       = top_q;
	assign stat.nxt       = rd_q;

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !stat.full && !cmd.replace)
		else $error("push onto full stack");

	a_replace_two: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.replace || cmd.rd) |-> !stat.below_two)
		else $error("pop with fewer than two entries");

endmodule

[hdl/stack_machine_executor.sv]
// ----------------------------------------------------------------------------
// stack_machine_executor: stack machine instruction executor
// Push, halt and refused items give their result in the cycle after acceptance;
// divide by zero is seen in the read state. Add, sub, mul and div go through the
// iterative unit (one multiplier or quotient bit per cycle through a shared
// 33-bit adder). One item at a time; the next is taken in the cycle its result
// is taken. Reset (arst_n low) empties the stack and clears the halted flag.
// ----------------------------------------------------------------------------
module stack_machine_executor #(
	parameter int STACK_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         opcode,
	input  logic signed [31:0] immediate,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic signed [31:0] top_value,
	output logic [6:0]         depth
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_EXEC = 3'b100
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic              halted_q;
	logic              halt_set;
	sm_pkg::alu_op_t   op_q;
	sm_pkg::alu_op_t   op_dec;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [31:0]       top_q;
	logic [6:0]        depth_q;
	logic              load_out;
	logic [2:0]        o_status;
	logic [31:0]       o_top;
	logic [6:0]        o_depth;
	logic              accept;
	logic              alu_start;
	logic              alu_done;
	logic [31:0]       alu_res;
	sm_pkg::stk_cmd_t  cmd;
	sm_pkg::stk_stat_t stat;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	always_comb begin
		unique case (opcode)
			sm_pkg::OP_ADD: op_dec = sm_pkg::ALU_ADD;
			sm_pkg::OP_SUB: op_dec = sm_pkg::ALU_SUB;
			sm_pkg::OP_MUL: op_dec = sm_pkg::ALU_MUL;
			default:        op_dec = sm_pkg::ALU_DIV;
		endcase
	end

	always_comb begin
		cmd       = '0;
		alu_start = 1'b0;
		load_out  = 1'b0;
		halt_set  = 1'b0;
		state_d   = state_q;
		o_status  = sm_pkg::ST_OK;
		o_top     = stat.empty ? 32'd0 : stat.top;
		o_depth   = stat.depth;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (halted_q) begin
						load_out = 1'b1;
						o_status = sm_pkg::ST_HALTED;
					end else if (opcode == sm_pkg::OP_HALT) begin
						load_out = 1'b1;
						halt_set = 1'b1;
						o_status = sm_pkg::ST_HALTED;
					end else if (opcode == sm_pkg::OP_PUSH) begin
						load_out = 1'b1;
						if (stat.full) begin
							o_status = sm_pkg::ST_OVERFLOW;
						end else begin
							cmd.push = 1'b1;
							cmd.data = immediate;
							o_top    = immediate;
							o_depth  = stat.depth + 7'd1;
						end
					end else if (opcode == sm_pkg::OP_ADD || opcode == sm_pkg::OP_SUB ||
					             opcode == sm_pkg::OP_MUL || opcode == sm_pkg::OP_DIV) begin
						if (stat.below_two) begin
							load_out = 1'b1;
							o_status = sm_pkg::ST_UNDERFLOW;
						end else begin
							cmd.rd  = 1'b1;
							state_d = S_READ;
						end
					end else begin
						load_out = 1'b1;
						o_status = sm_pkg::ST_UNKNOWN;
					end
				end
			end
			S_READ: begin
				if (op_q == sm_pkg::ALU_DIV && stat.nxt == 32'd0) begin
					load_out = 1'b1;
					o_status = sm_pkg::ST_DIVZERO;
					state_d  = S_IDLE;
				end else begin
					alu_start = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (alu_done) begin
					cmd.replace = 1'b1;
					cmd.data    = alu_res;
					load_out    = 1'b1;
					o_top       = alu_res;
					o_depth     = stat.depth - 7'd1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (halt_set) halted_q <= 1'b1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) op_q <= op_dec;
		if (load_out) begin
			status_q <= o_status;
			top_q    <= o_top;
			depth_q  <= o_depth;
		end
	end

	sm_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	sm_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (alu_start),
		.op     (op_q),
		.t      (stat.top),
		.n      (stat.nxt),
		.done   (alu_done),
		.res    (alu_res)
	);

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign top_value = top_q;
	assign depth     = depth_q;

	a_halted_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && halted_q) |=> (out_valid && status == sm_pkg::ST_HALTED))
		else $error("item after halt not refused");

	a_done_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> (state_q == S_EXEC))
		else $error("arithmetic result outside execute");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && state_q != S_IDLE) |-> !out_valid_q)
		else $error("result register overwritten");

endmodule
